// ===== design/fsrg_pkg.sv =====
// Package for the frame skip rate governor: widths, constants, rate tables,
// controller states and the command/status structs. Depends on nothing.
package fsrg_pkg;

  // Field widths.
  localparam int LOAD_W   = 8;
  localparam int RATE_W   = 8;
  localparam int DIV_W    = 5;
  localparam int LVL_W    = 4;
  localparam int SKIP_W   = 5;
  localparam int HIT_W    = 3;
  localparam int STREAK_W = 2;
  localparam int THR_W    = 7;
  localparam int DCNT_W   = $clog2(RATE_W);

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Default saturation point of the skip level.
  localparam int MAX_SKIP_INDEX_DEF = 15;

  // Reset values and limits.
  localparam logic [RATE_W-1:0]   TARGET_RESET = 8'd60;
  localparam logic [RATE_W-1:0]   TARGET_60    = 8'd60;
  localparam logic [RATE_W-1:0]   TARGET_30    = 8'd30;
  localparam logic [THR_W-1:0]    THR_RESET    = 7'd80;
  localparam logic [LOAD_W-1:0]   OVER_LOAD    = 8'd100;
  localparam logic [HIT_W-1:0]    HIT_LIMIT    = 3'd5;
  localparam logic [STREAK_W:0]   STREAK_LIMIT = 3'd2;
  localparam logic [LVL_W-1:0]    LVL_CAP_60   = 4'd5;
  localparam logic [LVL_W-1:0]    LVL_CAP_30   = 4'd4;
  localparam logic [DIV_W-1:0]    DIV_ONE      = 5'd1;

  // Fixed rate and divisor tables for the 60 Hz and 30 Hz targets.
  localparam logic [RATE_W-1:0] RATES_60 [6] = '{8'd60, 8'd30, 8'd20, 8'd15, 8'd12, 8'd10};
  localparam logic [DIV_W-1:0]  DIVS_60  [6] = '{5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd6};
  localparam logic [RATE_W-1:0] RATES_30 [5] = '{8'd30, 8'd15, 8'd10, 8'd6, 8'd5};
  localparam logic [DIV_W-1:0]  DIVS_30  [5] = '{5'd1, 5'd2, 5'd3, 5'd5, 5'd6};

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIVIDE,
    ST_HOLD
  } fsrg_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic eval;
    logic div_step;
    logic out_load;
  } fsrg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_needed;
    logic div_last;
  } fsrg_sts_t;

endpackage

// ===== design/fsrg_if.sv =====
// Valid/ready channel interfaces for frame requests and governor results.
// Depends on fsrg_pkg for the field widths.
interface fsrg_in_if;
  logic                        valid;
  logic                        ready;
  logic [fsrg_pkg::LOAD_W-1:0] cpu_load;
  logic                        slot_ready;

  modport source (output valid, output cpu_load, output slot_ready, input ready);
  modport sink   (input valid, input cpu_load, input slot_ready, output ready);
endinterface

interface fsrg_out_if;
  logic                        valid;
  logic                        ready;
  logic                        proceed;
  logic                        skipped;
  logic [fsrg_pkg::RATE_W-1:0] frame_rate;
  logic [fsrg_pkg::DIV_W-1:0]  skip_divisor;
  logic                        rate_changed;

  modport source (output valid, output proceed, output skipped, output frame_rate,
                  output skip_divisor, output rate_changed, input ready);
  modport sink   (input valid, input proceed, input skipped, input frame_rate,
                  input skip_divisor, input rate_changed, output ready);
endinterface

// ===== design/fsrg_ctrl.sv =====
// Controller of the frame skip rate governor: sequences capture, evaluation,
// the shared divider and the output register. Depends on fsrg_pkg.
module fsrg_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  fsrg_pkg::fsrg_sts_t sts_i,
  output fsrg_pkg::fsrg_cmd_t cmd_o
);
  import fsrg_pkg::*;

  fsrg_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.div_needed ? ST_DIVIDE : ST_HOLD;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        // The output register is free or its word leaves this cycle.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // An accepted word always goes to evaluation next.
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EVAL))
    else $error("accepted word did not reach evaluation");

  // Loading the output register always raises valid.
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("output load without valid");

  // The last divider step leads to the output stage.
  a_div_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE && sts_i.div_last) |=> (state_q == ST_HOLD))
    else $error("divider finish did not reach output stage");

endmodule

// ===== design/fsrg_datapath.sv =====
// Datapath of the frame skip rate governor: governor state, configuration
// register, restoring divider and output register. Depends on fsrg_pkg.
module fsrg_datapath #(
  parameter int MAX_SKIP_INDEX = fsrg_pkg::MAX_SKIP_INDEX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fsrg_pkg::fsrg_cmd_t         cmd_i,
  output fsrg_pkg::fsrg_sts_t         sts_o,
  input  logic                        cfg_we_i,
  input  logic [fsrg_pkg::RATE_W-1:0] cfg_data_i,
  output logic [fsrg_pkg::RATE_W-1:0] target_o,
  input  logic [fsrg_pkg::LOAD_W-1:0] cpu_load_i,
  input  logic                        slot_ready_i,
  output logic                        proceed_o,
  output logic                        skipped_o,
  output logic [fsrg_pkg::RATE_W-1:0] frame_rate_o,
  output logic [fsrg_pkg::DIV_W-1:0]  skip_divisor_o,
  output logic                        rate_changed_o
);
  import fsrg_pkg::*;

  localparam logic [LVL_W-1:0] LvlMax = LVL_W'(MAX_SKIP_INDEX);

  // Governor state.
  logic [RATE_W-1:0]   target_q, cur_rate_q, rate_d;
  logic [DIV_W-1:0]    cur_div_q, div_d;
  logic [SKIP_W-1:0]   skip_q, skip_d, skip_nxt;
  logic [HIT_W-1:0]    oh_q, oh_d, uh_q, uh_d, oh_inc, uh_inc;
  logic [LVL_W-1:0]    lvl_q, lvl_d, lvl_step;
  logic [STREAK_W-1:0] streak_q, streak_d;
  logic [STREAK_W:0]   streak_sum;
  logic [THR_W-1:0]    thr_q, thr_d;

  // Captured word and per-step flags.
  logic [LOAD_W-1:0] load_q;
  logic              slot_q;
  logic              proceed_q, changed_q;
  logic              proceed_d, changed_d, div_needed;
  logic              ovr, und, up, down;

  // Divider registers.
  logic [RATE_W-1:0] quo_q, quo_nxt;
  logic [DIV_W-1:0]  rem_q, rem_nxt, den_q;
  logic [DIV_W:0]    trial;
  logic [DCNT_W-1:0] dcnt_q;

  // Hit detection.
  assign ovr    = load_q > OVER_LOAD;
  assign und    = {1'b0, load_q} < {2'b00, thr_q};
  assign oh_inc = ovr ? oh_q + 1'b1 : oh_q;
  assign uh_inc = und ? uh_q + 1'b1 : uh_q;
  assign up     = oh_inc > HIT_LIMIT;
  assign down   = uh_inc > HIT_LIMIT;
  assign skip_nxt   = skip_q + 1'b1;
  assign streak_sum = {1'b0, streak_q} + {2'b00, up} + {2'b00, down};

  // One step of frame counting and governing.
  always_comb begin
    skip_d     = skip_q;
    oh_d       = oh_q;
    uh_d       = uh_q;
    lvl_d      = lvl_q;
    lvl_step   = lvl_q;
    streak_d   = streak_q;
    thr_d      = thr_q;
    rate_d     = cur_rate_q;
    div_d      = cur_div_q;
    proceed_d  = 1'b1;
    changed_d  = 1'b0;
    div_needed = 1'b0;
    if (skip_nxt < cur_div_q) begin
      skip_d = skip_nxt;
    end else if (!slot_q) begin
      proceed_d = 1'b0;
    end else begin
      skip_d = '0;
      if (!(target_q == cur_rate_q && load_q < OVER_LOAD)) begin
        if (!up && !down) begin
          oh_d = oh_inc;
          uh_d = uh_inc;
          if (!(ovr || und)) streak_d = '0;
        end else begin
          changed_d = 1'b1;
          oh_d      = '0;
          uh_d      = '0;
          if (streak_sum > STREAK_LIMIT) begin
            streak_d = '0;
            if (thr_q != '0) thr_d = thr_q - 1'b1;
          end else begin
            streak_d = streak_sum[STREAK_W-1:0];
          end
          // Level moves by one and saturates at both ends.
          if (up && !down && lvl_q < LvlMax) lvl_step = lvl_q + 1'b1;
          else if (down && !up && lvl_q != '0) lvl_step = lvl_q - 1'b1;
          if (target_q == TARGET_60) begin
            lvl_d  = (lvl_step > LVL_CAP_60) ? LVL_CAP_60 : lvl_step;
            rate_d = RATES_60[lvl_d[2:0]];
            div_d  = DIVS_60[lvl_d[2:0]];
          end else if (target_q == TARGET_30) begin
            lvl_d  = (lvl_step > LVL_CAP_30) ? LVL_CAP_30 : lvl_step;
            rate_d = RATES_30[lvl_d[2:0]];
            div_d  = DIVS_30[lvl_d[2:0]];
          end else begin
            lvl_d      = lvl_step;
            div_d      = {1'b0, lvl_step} + DIV_ONE;
            div_needed = 1'b1;
          end
        end
      end
    end
  end

  // Restoring division step: one quotient bit per cycle.
  always_comb begin
    trial = {rem_q, quo_q[RATE_W-1]};
    if (trial >= {1'b0, den_q}) begin
      rem_nxt = DIV_W'(trial - {1'b0, den_q});
      quo_nxt = {quo_q[RATE_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[DIV_W-1:0];
      quo_nxt = {quo_q[RATE_W-2:0], 1'b0};
    end
  end

  assign sts_o.div_needed = div_needed;
  assign sts_o.div_last   = (dcnt_q == DCNT_W'(RATE_W - 1));

  // Control-relevant state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= TARGET_RESET;
      cur_rate_q <= TARGET_RESET;
      cur_div_q  <= DIV_ONE;
      skip_q     <= '0;
      oh_q       <= '0;
      uh_q       <= '0;
      lvl_q      <= '0;
      streak_q   <= '0;
      thr_q      <= THR_RESET;
      dcnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        // A new target restarts the governor.
        target_q   <= cfg_data_i;
        cur_rate_q <= cfg_data_i;
        cur_div_q  <= DIV_ONE;
        oh_q       <= '0;
        uh_q       <= '0;
        lvl_q      <= '0;
      end else if (cmd_i.eval) begin
        cur_rate_q <= rate_d;
        cur_div_q  <= div_d;
        skip_q     <= skip_d;
        oh_q       <= oh_d;
        uh_q       <= uh_d;
        lvl_q      <= lvl_d;
        streak_q   <= streak_d;
        thr_q      <= thr_d;
        dcnt_q     <= '0;
      end else if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q + 1'b1;
        if (sts_o.div_last) cur_rate_q <= quo_nxt;
      end
    end
  end

  // Payload registers: captured word, divider operands and output word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      load_q <= cpu_load_i;
      slot_q <= slot_ready_i;
    end
    if (cmd_i.eval) begin
      proceed_q <= proceed_d;
      changed_q <= changed_d;
      quo_q     <= target_q;
      rem_q     <= '0;
      den_q     <= div_d;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_nxt;
      rem_q <= rem_nxt;
    end
    if (cmd_i.out_load) begin
      proceed_o      <= proceed_q;
      skipped_o      <= (skip_q != '0);
      frame_rate_o   <= cur_rate_q;
      skip_divisor_o <= cur_div_q;
      rate_changed_o <= changed_q;
    end
  end

  assign target_o = target_q;

  // The divisor in force is always between one and sixteen.
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_div_q != '0) && (cur_div_q <= DIV_W'(16)))
    else $error("skip divisor out of range");

  // The skip level never passes its saturation point.
  a_lvl_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lvl_q <= LvlMax)
    else $error("skip level above maximum");

  // The underload threshold only ever falls, and only by one.
  a_thr_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (thr_q != $past(thr_q)) |-> (thr_q == $past(thr_q) - 1'b1))
    else $error("underload threshold moved unexpectedly");

endmodule

// ===== design/frame_skip_rate_governor.sv =====
// Frame skip rate governor. An accepted word passes the evaluation and output states
// into the output register; a new rate from the target division (8 divider steps)
// adds the divide state between them. The restoring divider gives one quotient bit
// per cycle. A new word is taken only after the last one is in the output register.
// A stalled result holds the block in its output stage until the word leaves.
// Reset: rst_ni is asynchronous and active low; target rate 60, divisor 1,
// threshold 80, all counters zero, no result pending.
module frame_skip_rate_governor #(
  parameter int MAX_SKIP_INDEX = fsrg_pkg::MAX_SKIP_INDEX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fsrg_pkg::APB_AW-1:0] paddr,
  input  logic [fsrg_pkg::APB_DW-1:0] pwdata,
  output logic [fsrg_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  fsrg_in_if.sink                     in_i,
  fsrg_out_if.source                  out_o
);
  import fsrg_pkg::*;

  fsrg_cmd_t         cmd;
  fsrg_sts_t         sts;
  logic              cfg_we;
  logic              reg_hit;
  logic [RATE_W-1:0] target;

  // Register decode: the target rate answers at byte addresses zero to three.
  assign reg_hit = (paddr[APB_AW-1] == 1'b0);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(APB_DW - RATE_W){1'b0}}, target} : '0;

  fsrg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fsrg_datapath #(
    .MAX_SKIP_INDEX (MAX_SKIP_INDEX)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we),
    .cfg_data_i     (pwdata[RATE_W-1:0]),
    .target_o       (target),
    .cpu_load_i     (in_i.cpu_load),
    .slot_ready_i   (in_i.slot_ready),
    .proceed_o      (out_o.proceed),
    .skipped_o      (out_o.skipped),
    .frame_rate_o   (out_o.frame_rate),
    .skip_divisor_o (out_o.skip_divisor),
    .rate_changed_o (out_o.rate_changed)
  );

endmodule
